// File: hw/rtl/psnr_pkg.sv
// ----------------------------------------------------------------------------
// psnr_pkg: shared constants and types for the frame PSNR meter
// Widths, fixed-point constants and the job/result words passed between the
// accumulator and the end-of-frame calculation unit.
// ----------------------------------------------------------------------------
package psnr_pkg;

  localparam int PIXEL_COUNT_BITS = 24;
  localparam int CNT_W            = PIXEL_COUNT_BITS;
  localparam int SAMPLE_W         = 8;
  localparam int SQ_W             = 2 * SAMPLE_W;
  localparam int NUM_LANES        = 3;
  localparam int ADD_W            = SQ_W + 2;
  localparam int FAC_W            = 18;
  localparam int SSE_W            = CNT_W + FAC_W;
  localparam int CHAN_W           = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [FAC_W-1:0] PEAK_SQ   = FAC_W'(65025);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(3);

  // log2 in fixed point: integer part E_W bits, fraction LOG_FRAC bits
  localparam int MANT_W   = 32;
  localparam int NORM_W   = (SSE_W > MANT_W) ? SSE_W : MANT_W;
  localparam int E_W      = $clog2(NORM_W);
  localparam int LOG_FRAC = 30;
  localparam int LOG_W    = E_W + LOG_FRAC;
  localparam int ITER_W   = $clog2(LOG_FRAC);
  localparam int D_SHIFT  = 10;
  localparam int D_W      = LOG_W - D_SHIFT;

  // dB scale = round(2560 * log10(2) * 2^28), split in two halves
  localparam int DB_W        = 38;
  localparam int DB_LO_W     = 19;
  localparam int DB_HI_W     = DB_W - DB_LO_W;
  localparam logic [DB_W-1:0] DB_SCALE = 38'd206866237836;
  localparam int PROD_W      = D_W + DB_LO_W;
  localparam int TOT_W       = D_W + DB_W;
  localparam int SCALE_SHIFT = 48;

  localparam int PSNR_W = 15;
  localparam logic [PSNR_W-1:0] PSNR_MAX = {PSNR_W{1'b1}};

  typedef struct packed {
    logic [SSE_W-1:0]  sse;
    logic [CNT_W-1:0]  count;
    logic [CHAN_W-1:0] chan;
    logic              ovf;
  } psnr_job_t;

  typedef struct packed {
    logic [PSNR_W-1:0] psnr;
    logic              ident;
    logic              ovf;
  } psnr_res_t;

endpackage

// File: hw/rtl/frame_psnr_meter.sv
// ----------------------------------------------------------------------------
// frame_psnr_meter: PSNR between a reference and a test frame
// Three channel lanes feed a merge adder and the frame accumulators; the
// end-of-frame unit turns the sums into dB.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one pixel pair per word (in_ref_ch*, in_test_ch*,
//   in_last_pixel), accepted when in_valid is high and in_stall is low.
//   Pixels are taken one per cycle while in_stall is low; the lanes and the
//   accumulators update in the cycle of acceptance.
//   A word with in_last_pixel set closes the frame: its sums go to the
//   calculation unit and the accumulators clear, so the next frame streams in
//   at once. The unit is busy while it forms the numerator, normalizes and
//   runs 30 squaring steps in each log2 unit, then scales to dB and hands
//   the result off; a further last word is stalled until the unit is done.
//   Output channel: one word per frame from an output register, valid until
//   taken (out_valid high, out_stall low). A stalled output holds the
//   calculation unit, and with it the next frame's last word.
//   cfg_we writes channels_used (0 to 3) from cfg_wdata.
//   Reset (rst_n low, synchronous) clears the sums, the pixel count, the
//   overflow flag and the output valid, and sets channels_used to 3.
// ----------------------------------------------------------------------------
module frame_psnr_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [psnr_pkg::CHAN_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_ref_ch0,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_ref_ch1,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_ref_ch2,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_test_ch0,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_test_ch1,
  input  logic [psnr_pkg::SAMPLE_W-1:0]       in_test_ch2,
  input  logic                                in_last_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psnr_pkg::PSNR_W-1:0]         out_psnr_db_q8,
  output logic                                out_identical_frames,
  output logic                                out_count_overflow
);

  logic [psnr_pkg::CHAN_W-1:0]   chan_r;
  logic [psnr_pkg::SSE_W-1:0]    sse_r, sse_nxt;
  logic [psnr_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r;
  psnr_pkg::psnr_res_t           out_r;

  logic [psnr_pkg::SAMPLE_W-1:0] ref_a  [psnr_pkg::NUM_LANES];
  logic [psnr_pkg::SAMPLE_W-1:0] test_a [psnr_pkg::NUM_LANES];
  logic [psnr_pkg::SQ_W-1:0]     sq_a   [psnr_pkg::NUM_LANES];
  logic [psnr_pkg::ADD_W-1:0]    add_w;

  logic                          in_acc;
  logic                          calc_busy, res_valid, res_take;
  psnr_pkg::psnr_job_t           job_w;
  psnr_pkg::psnr_res_t           res_w;

  assign ref_a[0]  = in_ref_ch0;
  assign ref_a[1]  = in_ref_ch1;
  assign ref_a[2]  = in_ref_ch2;
  assign test_a[0] = in_test_ch0;
  assign test_a[1] = in_test_ch1;
  assign test_a[2] = in_test_ch2;

  for (genvar g = 0; g < psnr_pkg::NUM_LANES; g++) begin : g_lane
    psnr_lane u_lane (
      .ref_s  (ref_a[g]),
      .test_s (test_a[g]),
      .enable (chan_r > psnr_pkg::CHAN_W'(g)),
      .sq     (sq_a[g])
    );
  end

  // merge the lanes
  assign add_w = psnr_pkg::ADD_W'(sq_a[0]) + psnr_pkg::ADD_W'(sq_a[1])
               + psnr_pkg::ADD_W'(sq_a[2]);

  // hold a closing word while the previous frame is still in the unit
  assign in_stall = calc_busy & in_last_pixel;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    sse_nxt = sse_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cnt_r == psnr_pkg::COUNT_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      sse_nxt = sse_r + psnr_pkg::SSE_W'(add_w);
      cnt_nxt = cnt_r + psnr_pkg::CNT_W'(1);
    end
  end

  assign job_w.sse   = sse_nxt;
  assign job_w.count = cnt_nxt;
  assign job_w.chan  = chan_r;
  assign job_w.ovf   = ovf_nxt;

  psnr_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc & in_last_pixel),
    .job       (job_w),
    .busy      (calc_busy),
    .res_valid (res_valid),
    .res       (res_w),
    .res_take  (res_take)
  );

  assign res_take = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= psnr_pkg::CHAN_RESET;
      sse_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        chan_r <= cfg_wdata;
      end
      if (in_acc) begin
        if (in_last_pixel) begin
          sse_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sse_r <= sse_nxt;
          cnt_r <= cnt_nxt;
          ovf_r <= ovf_nxt;
        end
      end
      if (res_valid && res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && res_take) begin
      out_r <= res_w;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_psnr_db_q8       = out_r.psnr;
  assign out_identical_frames = out_r.ident;
  assign out_count_overflow   = out_r.ovf;

endmodule

// File: hw/rtl/psnr_lane.sv
// ----------------------------------------------------------------------------
// psnr_lane: squared difference of one colour channel
// Gives (ref - test)^2, or zero when the channel is not in use.
// ----------------------------------------------------------------------------
module psnr_lane (
  input  logic [psnr_pkg::SAMPLE_W-1:0] ref_s,
  input  logic [psnr_pkg::SAMPLE_W-1:0] test_s,
  input  logic                          enable,
  output logic [psnr_pkg::SQ_W-1:0]     sq
);

  logic [psnr_pkg::SAMPLE_W-1:0] diff_w;

  assign diff_w = (ref_s >= test_s) ? (ref_s - test_s) : (test_s - ref_s);
  assign sq     = enable ? (psnr_pkg::SQ_W'(diff_w) * psnr_pkg::SQ_W'(diff_w))
                         : '0;

endmodule

// File: hw/rtl/psnr_log2.sv
// ----------------------------------------------------------------------------
// psnr_log2: iterative fixed-point base-2 logarithm
// Normalizes the operand in shifts of eight bits or one bit, then derives one
// fraction bit per cycle by repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
module psnr_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psnr_pkg::SSE_W-1:0]    value,
  output logic                          busy,
  output logic                          is_zero,
  output logic [psnr_pkg::LOG_W-1:0]    result
);

  typedef enum logic [2:0] {
    LG_IDLE = 3'b001,
    LG_NORM = 3'b010,
    LG_ITER = 3'b100
  } lg_state_t;

  lg_state_t                         state_r, state_nxt;
  logic [psnr_pkg::NORM_W-1:0]       v_r, v_nxt;
  logic [psnr_pkg::E_W-1:0]          e_r, e_nxt;
  logic [psnr_pkg::MANT_W-1:0]       y_r, y_nxt;
  logic [psnr_pkg::LOG_FRAC-1:0]     frac_r, frac_nxt;
  logic [psnr_pkg::ITER_W-1:0]       cnt_r, cnt_nxt;
  logic                              zero_r, zero_nxt;
  logic [2*psnr_pkg::MANT_W-1:0]     sq_w;
  logic [psnr_pkg::MANT_W:0]         sh_w;

  assign sq_w = {{psnr_pkg::MANT_W{1'b0}}, y_r} * {{psnr_pkg::MANT_W{1'b0}}, y_r};
  assign sh_w = sq_w[2*psnr_pkg::MANT_W-1:psnr_pkg::MANT_W-1];

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    e_nxt     = e_r;
    y_nxt     = y_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    unique case (state_r)
      LG_IDLE: begin
        if (start) begin
          v_nxt    = psnr_pkg::NORM_W'(value);
          e_nxt    = psnr_pkg::E_W'(psnr_pkg::NORM_W - 1);
          zero_nxt = (value == '0);
          frac_nxt = '0;
          if (value != '0) begin
            state_nxt = LG_NORM;
          end
        end
      end
      LG_NORM: begin
        // move the top set bit up to the msb, eight places where possible
        if (v_r[psnr_pkg::NORM_W-1]) begin
          y_nxt     = v_r[psnr_pkg::NORM_W-1 -: psnr_pkg::MANT_W];
          cnt_nxt   = '0;
          state_nxt = LG_ITER;
        end else if (v_r[psnr_pkg::NORM_W-1 -: 8] == '0) begin
          v_nxt = v_r << 8;
          e_nxt = e_r - psnr_pkg::E_W'(8);
        end else begin
          v_nxt = v_r << 1;
          e_nxt = e_r - psnr_pkg::E_W'(1);
        end
      end
      LG_ITER: begin
        if (sh_w[psnr_pkg::MANT_W]) begin
          y_nxt    = sh_w[psnr_pkg::MANT_W:1];
          frac_nxt = {frac_r[psnr_pkg::LOG_FRAC-2:0], 1'b1};
        end else begin
          y_nxt    = sh_w[psnr_pkg::MANT_W-1:0];
          frac_nxt = {frac_r[psnr_pkg::LOG_FRAC-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + psnr_pkg::ITER_W'(1);
        if (cnt_r == psnr_pkg::ITER_W'(psnr_pkg::LOG_FRAC - 1)) begin
          state_nxt = LG_IDLE;
        end
      end
      default: state_nxt = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r    <= v_nxt;
    e_r    <= e_nxt;
    y_r    <= y_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  assign busy    = (state_r != LG_IDLE);
  assign is_zero = zero_r;
  assign result  = {e_r, frac_r};

endmodule

// File: hw/rtl/psnr_calc.sv
// ----------------------------------------------------------------------------
// psnr_calc: end-of-frame PSNR calculation
// Forms the numerator, runs both logarithms side by side, scales the
// difference to dB in two partial products, rounds and saturates.
// ----------------------------------------------------------------------------
module psnr_calc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  psnr_pkg::psnr_job_t job,
  output logic                busy,
  output logic                res_valid,
  output psnr_pkg::psnr_res_t res,
  input  logic                res_take
);

  typedef enum logic [7:0] {
    CL_IDLE   = 8'b0000_0001,
    CL_NUM    = 8'b0000_0010,
    CL_LOGGO  = 8'b0000_0100,
    CL_LOG    = 8'b0000_1000,
    CL_MUL_LO = 8'b0001_0000,
    CL_MUL_HI = 8'b0010_0000,
    CL_SUM    = 8'b0100_0000,
    CL_HOLD   = 8'b1000_0000
  } cl_state_t;

  cl_state_t                      state_r, state_nxt;
  psnr_pkg::psnr_job_t            job_r;
  logic [psnr_pkg::SSE_W-1:0]     num_r;
  logic [psnr_pkg::D_W-1:0]       d_r;
  logic [psnr_pkg::PROD_W-1:0]    plo_r, phi_r;
  psnr_pkg::psnr_res_t            res_r;
  logic [psnr_pkg::FAC_W-1:0]     fac_w;
  logic                           log_start;
  logic                           num_busy, sse_busy, num_zero, sse_zero;
  logic [psnr_pkg::LOG_W-1:0]     ln_w, ld_w, diff_w;
  logic [psnr_pkg::TOT_W-1:0]     tot_w;

  assign fac_w     = psnr_pkg::PEAK_SQ * psnr_pkg::FAC_W'(job_r.chan);
  assign log_start = (state_r == CL_LOGGO);

  psnr_log2 u_log_num (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (log_start),
    .value   (num_r),
    .busy    (num_busy),
    .is_zero (num_zero),
    .result  (ln_w)
  );

  psnr_log2 u_log_sse (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (log_start),
    .value   (job_r.sse),
    .busy    (sse_busy),
    .is_zero (sse_zero),
    .result  (ld_w)
  );

  assign diff_w = ln_w - ld_w;
  assign tot_w  = {phi_r, {psnr_pkg::DB_LO_W{1'b0}}} + psnr_pkg::TOT_W'(plo_r)
                + (psnr_pkg::TOT_W'(1) << (psnr_pkg::SCALE_SHIFT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CL_IDLE:   if (start) state_nxt = CL_NUM;
      CL_NUM:    state_nxt = CL_LOGGO;
      CL_LOGGO:  state_nxt = CL_LOG;
      CL_LOG:    if (!num_busy && !sse_busy) state_nxt = CL_MUL_LO;
      CL_MUL_LO: state_nxt = CL_MUL_HI;
      CL_MUL_HI: state_nxt = CL_SUM;
      CL_SUM:    state_nxt = CL_HOLD;
      CL_HOLD:   if (res_take) state_nxt = CL_IDLE;
      default:   state_nxt = CL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == CL_IDLE && start) begin
      job_r <= job;
    end
    if (state_r == CL_NUM) begin
      num_r <= psnr_pkg::SSE_W'(fac_w) * psnr_pkg::SSE_W'(job_r.count);
    end
    if (state_r == CL_LOG) begin
      // a ratio below one, or a zero numerator, reads as 0 dB
      if (!num_zero && !sse_zero && (ln_w > ld_w)) begin
        d_r <= diff_w[psnr_pkg::LOG_W-1:psnr_pkg::D_SHIFT];
      end else begin
        d_r <= '0;
      end
    end
    if (state_r == CL_MUL_LO) begin
      plo_r <= psnr_pkg::PROD_W'(d_r) *
               psnr_pkg::PROD_W'(psnr_pkg::DB_SCALE[psnr_pkg::DB_LO_W-1:0]);
    end
    if (state_r == CL_MUL_HI) begin
      phi_r <= psnr_pkg::PROD_W'(d_r) *
               psnr_pkg::PROD_W'(psnr_pkg::DB_SCALE[psnr_pkg::DB_W-1:psnr_pkg::DB_LO_W]);
    end
    if (state_r == CL_SUM) begin
      res_r.ident <= (job_r.sse == '0);
      res_r.ovf   <= job_r.ovf;
      if (job_r.sse == '0) begin
        res_r.psnr <= '0;
      end else if (|tot_w[psnr_pkg::TOT_W-1:psnr_pkg::SCALE_SHIFT+psnr_pkg::PSNR_W]) begin
        res_r.psnr <= psnr_pkg::PSNR_MAX;
      end else begin
        res_r.psnr <= tot_w[psnr_pkg::SCALE_SHIFT +: psnr_pkg::PSNR_W];
      end
    end
  end

  assign busy      = (state_r != CL_IDLE);
  assign res_valid = (state_r == CL_HOLD);
  assign res       = res_r;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for frame_psnr_meter
// Streams pixel pairs through the input channel in random bursts. A bit-exact
// predictor of the frame sums and the fixed-point log2/dB chain gives one
// result per closed frame, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int CALC_WAIT    = 80;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic [2:0][psnr_pkg::SAMPLE_W-1:0] ref_px;
    logic [2:0][psnr_pkg::SAMPLE_W-1:0] tst_px;
    logic                               last;
  } pixel_word_t;

  typedef enum {PX_RANDOM, PX_NEAR, PX_SAME, PX_EXTREME} px_mode_t;
  typedef enum {ST_FREE, ST_RAND, ST_ALT, ST_HOLD} stall_mode_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [psnr_pkg::CHAN_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [psnr_pkg::SAMPLE_W-1:0] in_ref_ch0 = '0, in_ref_ch1 = '0, in_ref_ch2 = '0;
  logic [psnr_pkg::SAMPLE_W-1:0] in_test_ch0 = '0, in_test_ch1 = '0, in_test_ch2 = '0;
  logic                          in_last_pixel = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [psnr_pkg::PSNR_W-1:0]   out_psnr_db_q8;
  logic                          out_identical_frames;
  logic                          out_count_overflow;

  frame_psnr_meter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ref_ch0           (in_ref_ch0),
    .in_ref_ch1           (in_ref_ch1),
    .in_ref_ch2           (in_ref_ch2),
    .in_test_ch0          (in_test_ch0),
    .in_test_ch1          (in_test_ch1),
    .in_test_ch2          (in_test_ch2),
    .in_last_pixel        (in_last_pixel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_psnr_db_q8       (out_psnr_db_q8),
    .out_identical_frames (out_identical_frames),
    .out_count_overflow   (out_count_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Frame state mirrored from the block
  logic [63:0]                 err_sum;
  logic [63:0]                 pix_count;
  logic                        ovf_seen;
  logic [psnr_pkg::CHAN_W-1:0] chan_now;

  pixel_word_t         pixel_q[$];
  psnr_pkg::psnr_res_t psnr_want_q[$];
  int                  fail_count = 0;
  logic                in_took = 1'b0;
  logic                hold_req = 1'b0;

  function automatic logic [63:0] log2_q30(logic [63:0] v);
    int          e;
    logic [63:0] y;
    logic [63:0] r;
    if (v == 0) return 64'd0;
    e = 63;
    while (v[e] == 1'b0) e--;
    y = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
    r = 64'(e) << psnr_pkg::LOG_FRAC;
    for (int i = psnr_pkg::LOG_FRAC - 1; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] sq_err(logic [psnr_pkg::SAMPLE_W-1:0] a,
                                         logic [psnr_pkg::SAMPLE_W-1:0] b);
    logic [63:0] d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // Add one pixel to the frame sums; on the frame's last pixel queue the dB result
  task automatic accumulate_pixel(pixel_word_t w);
    logic [63:0]         add, num, ln, ld, db;
    psnr_pkg::psnr_res_t res;
    if (pix_count >= 64'(psnr_pkg::COUNT_MAX)) begin
      ovf_seen = 1'b1;
    end else begin
      add = 0;
      for (int c = 0; c < 3; c++)
        if (chan_now > c) add += sq_err(w.ref_px[c], w.tst_px[c]);
      err_sum   += add;
      pix_count += 1;
    end
    if (!w.last) return;
    res = '0;
    if (err_sum == 0) begin
      res.ident = 1'b1;
    end else begin
      num = 64'd65025 * 64'(chan_now) * pix_count;
      ln  = log2_q30(num);
      ld  = log2_q30(err_sum);
      if (num != 0 && ln > ld) begin
        db = (((ln - ld) >> 10) * 64'(psnr_pkg::DB_SCALE) + (64'd1 << 47)) >> 48;
        res.psnr = (db > 64'(psnr_pkg::PSNR_MAX)) ? psnr_pkg::PSNR_MAX
                                                  : db[psnr_pkg::PSNR_W-1:0];
      end
    end
    res.ovf = ovf_seen;
    psnr_want_q.push_back(res);
    err_sum   = 0;
    pix_count = 0;
    ovf_seen  = 1'b0;
  endtask

  // Check results, predict accepted pixels, then follow config writes
  always @(posedge clk) begin
    psnr_pkg::psnr_res_t want;
    pixel_word_t         w;
    in_took = 1'b0;
    if (!rst_n) begin
      err_sum   = 0;
      pix_count = 0;
      ovf_seen  = 1'b0;
      chan_now  = psnr_pkg::CHAN_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (psnr_want_q.size() == 0) begin
          $error("unexpected result word: psnr_db_q8 %0d", out_psnr_db_q8);
          fail_count++;
        end else begin
          want = psnr_want_q.pop_front();
          if (out_psnr_db_q8 !== want.psnr) begin
            $error("psnr_db_q8: expected %0d, got %0d", want.psnr, out_psnr_db_q8);
            fail_count++;
          end
          if (out_identical_frames !== want.ident) begin
            $error("identical_frames: expected %0b, got %0b", want.ident,
                   out_identical_frames);
            fail_count++;
          end
          if (out_count_overflow !== want.ovf) begin
            $error("count_overflow: expected %0b, got %0b", want.ovf, out_count_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_took  = 1'b1;
        w.ref_px = {in_ref_ch2, in_ref_ch1, in_ref_ch0};
        w.tst_px = {in_test_ch2, in_test_ch1, in_test_ch0};
        w.last   = in_last_pixel;
        accumulate_pixel(w);
      end
      // the register takes its new value after this edge
      if (cfg_we) chan_now = cfg_wdata;
    end
  end

  // Input driver: bursts of words with random gaps
  int burst_left = 20;
  int gap_left = 0;

  always @(negedge clk) begin
    pixel_word_t w;
    if (rst_n && (!in_valid || in_took)) begin
      if (in_took) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 4) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 40);
          else gap_left = $urandom_range(1, 4);
        end
      end
      if (gap_left == 0 && pixel_q.size() != 0) begin
        w = pixel_q.pop_front();
        in_ref_ch0    <= w.ref_px[0];
        in_ref_ch1    <= w.ref_px[1];
        in_ref_ch2    <= w.ref_px[2];
        in_test_ch0   <= w.tst_px[0];
        in_test_ch1   <= w.tst_px[1];
        in_test_ch2   <= w.tst_px[2];
        in_last_pixel <= w.last;
        in_valid      <= 1'b1;
      end else begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall in segments of varying character
  stall_mode_t stall_mode = ST_FREE;
  int          seg_left = 0;

  always @(negedge clk) begin
    int r;
    if (hold_req) begin
      stall_mode = ST_HOLD;
      seg_left   = LONG_HOLD;
      hold_req   = 1'b0;
    end else if (seg_left <= 0) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        stall_mode = ST_FREE;
        seg_left   = $urandom_range(10, 80);
      end else if (r < 75) begin
        stall_mode = ST_RAND;
        seg_left   = $urandom_range(10, 60);
      end else if (r < 95) begin
        stall_mode = ST_ALT;
        seg_left   = $urandom_range(4, 30);
      end else begin
        stall_mode = ST_HOLD;
        seg_left   = $urandom_range(50, 200);
      end
    end
    seg_left--;
    case (stall_mode)
      ST_FREE: out_stall <= 1'b0;
      ST_RAND: out_stall <= ($urandom_range(0, 99) < 40);
      ST_ALT:  out_stall <= ~out_stall;
      default: out_stall <= 1'b1;
    endcase
  end

  function automatic pixel_word_t make_pixel(px_mode_t mode, logic last);
    pixel_word_t w;
    for (int c = 0; c < 3; c++) begin
      w.ref_px[c] = 8'($urandom);
      case (mode)
        PX_SAME:    w.tst_px[c] = w.ref_px[c];
        PX_NEAR:    w.tst_px[c] = w.ref_px[c] + 8'($urandom_range(0, 4)) - 8'd2;
        PX_EXTREME: begin
          w.ref_px[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          w.tst_px[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default:    w.tst_px[c] = 8'($urandom);
      endcase
    end
    w.last = last;
    return w;
  endfunction

  task automatic queue_px(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2,
                          logic [7:0] t0, logic [7:0] t1, logic [7:0] t2, logic last);
    pixel_word_t w;
    w.ref_px = {r2, r1, r0};
    w.tst_px = {t2, t1, t0};
    w.last   = last;
    pixel_q.push_back(w);
  endtask

  task automatic queue_frame(int len, logic closed);
    px_mode_t mode;
    int       r;
    r = $urandom_range(0, 99);
    mode = (r < 40) ? PX_RANDOM : (r < 70) ? PX_NEAR : (r < 85) ? PX_SAME : PX_EXTREME;
    for (int i = 0; i < len; i++)
      pixel_q.push_back(make_pixel(($urandom_range(0, 49) == 0) ? PX_RANDOM : mode,
                                   closed && (i == len - 1)));
  endtask

  // Drain all words, collect every result, then let the calc unit go quiet
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    while (psnr_want_q.size() != 0) @(posedge clk);
    repeat (CALC_WAIT) @(posedge clk);
  endtask

  task automatic set_channels(logic [psnr_pkg::CHAN_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int sent, done, ph, budget, len, r;
    logic tiny;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identical single pixel, then full-scale error (ratio of one)
    queue_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_px(8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h80, 1'b0);
    queue_px(8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h7F, 1'b0);
    queue_px(8'hAA, 8'h55, 8'h0F, 8'hAA, 8'h55, 8'h0F, 1'b1);
    queue_px(8'h10, 8'h20, 8'h30, 8'h11, 8'h20, 8'h30, 1'b1);
    // one channel: errors on the unused channels must not count
    set_channels(2'd1);
    queue_px(8'h05, 8'h00, 8'hFF, 8'h05, 8'hFF, 8'h00, 1'b0);
    queue_px(8'hFF, 8'h12, 8'h34, 8'hFF, 8'h56, 8'h78, 1'b1);
    set_channels(2'd2);
    queue_px(8'h00, 8'hFF, 8'h09, 8'hFF, 8'h00, 8'h09, 1'b0);
    queue_px(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 1'b1);
    // zero channels: nothing enters the sum
    set_channels(2'd0);
    queue_px(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
    // drop channel count mid-frame so the ratio falls below one
    set_channels(2'd3);
    repeat (3) queue_px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    set_channels(2'd1);
    queue_px(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);

    sent = 0;
    ph   = 0;
    while (sent < RANDOM_ITEMS) begin
      set_channels((ph == 0) ? 2'd3 : (ph == 1) ? 2'd1 :
                   psnr_pkg::CHAN_W'($urandom_range(1, 3)));
      tiny = (ph == 1) || ($urandom_range(0, 4) == 0);
      // hold the receiver off while tiny frames pile up behind it
      if (ph == 1) hold_req = 1'b1;
      budget = $urandom_range(100, 250);
      done   = 0;
      while (done < budget) begin
        r = $urandom_range(0, 99);
        if (tiny)        len = $urandom_range(1, 3);
        else if (r < 8)  len = $urandom_range(100, 300);
        else if (r < 35) len = $urandom_range(1, 4);
        else             len = $urandom_range(5, 40);
        done += len;
        // leave some frames open across the next register write
        queue_frame(len, (done < budget) || ($urandom_range(0, 3) != 0));
      end
      sent += done;
      ph++;
    end

    settle();
    if (fail_count == 0)
      $display("[frame_psnr_meter] OK");
    else
      $display("[frame_psnr_meter] ERROR");
    $finish;
  end

  initial begin
    #10000000;
    $display("[frame_psnr_meter] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/psnr_pkg.sv
hw/rtl/psnr_lane.sv
hw/rtl/psnr_log2.sv
hw/rtl/psnr_calc.sv
hw/rtl/frame_psnr_meter.sv
tb/tb.sv
